// ----- rtl/afr3d_pkg.sv -----
package afr3d_pkg;

    // Fixed formats of the ports and of the internal datapath.
    localparam int unsigned COORD_W         = 32;   // Q15.16 coordinates
    localparam int unsigned ANGLE_W         = 32;   // 2^32 per full turn
    localparam int unsigned ACC_W           = 64;   // CORDIC word, Q60
    localparam int unsigned SC_FRAC         = 30;   // cos/sin in Q30
    localparam int unsigned TRIG_STAGES_DEF = 24;
    localparam int unsigned TRIG_STAGES_MAX = 48;

    // pi in Q61, split in two halves for the angle multipliers
    localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;
    localparam logic [31:0] PI_HI  = PI_Q61[63:32];
    localparam logic [31:0] PI_LO  = PI_Q61[31:0];

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic [ANGLE_W-1:0]        t_angle;

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    // Side data that rides along the pipeline with every request.
    typedef struct packed {
        t_coord     a;      // operand multiplied by cos in the first output
        t_coord     b;      // operand multiplied by sin in the first output
        t_coord     pass;   // component on the rotation axis
        t_axis      axis;
        logic [1:0] quad;   // quadrant of the angle
    } t_meta;

    // Elaboration-time long division.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] vv;
        logic [63:0] res;
        logic [63:0] bt;
        vv  = val;
        res = '0;
        bt  = 64'd1 << 62;
        for (int n = 0; n < 32; n++) begin
            if (bt > vv) bt = bt >> 2;
        end
        for (int n = 0; n < 32; n++) begin
            if (bt != 64'd0) begin
                if (vv >= res + bt) begin
                    vv  = vv - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
        end
        return res;
    endfunction

    // Arctangent of 2^-idx in Q60 from the truncated series in Q62.
    function automatic logic [63:0] atan_q60(input int unsigned idx);
        logic [63:0] sum;
        logic [63:0] term;
        int unsigned sh;
        sum = '0;
        if (idx == 0) return PI_Q61 >> 3;
        for (int unsigned k = 0; k < 32; k++) begin
            sh = idx * (2 * k + 1);
            if (sh <= 62) begin
                term = udiv64(64'd1 << (62 - sh), 64'(2 * k + 1));
                if (k[0]) sum = sum - term;
                else      sum = sum + term;
            end
        end
        return (sum + 64'd2) >> 2;
    endfunction

    // Start value of the CORDIC x register: gain compensation in Q60.
    function automatic logic [63:0] cordic_k(input int unsigned stages);
        logic [63:0] v;
        v = 64'd1 << 62;
        for (int unsigned i = 0; i < 32; i++) begin
            if (i < stages) v = v - udiv64(v, (64'd1 << (2 * i)) + 64'd1);
        end
        return isqrt64(v) << 29;
    endfunction

endpackage

// ----- rtl/afr3d_angle.sv -----
module afr3d_angle (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  afr3d_pkg::t_angle i_angle,
    input  afr3d_pkg::t_meta  i_meta,
    output logic              o_valid,
    output afr3d_pkg::t_acc   o_z,
    output afr3d_pkg::t_meta  o_meta
);
    import afr3d_pkg::*;

    localparam int unsigned PL_W = 2 * ANGLE_W + 1;

    logic [ANGLE_W-1:0]        w_shift;
    logic [1:0]                w_quad;
    logic signed [ANGLE_W-1:0] w_res;
    logic signed [PL_W-1:0]    w_pl;
    t_meta                     w_meta;

    logic                      r_va;
    t_meta                     r_meta_a;
    t_acc                      r_ph;
    logic signed [ANGLE_W:0]   r_pl;
    logic                      r_vb;
    t_acc                      r_z;
    t_meta                     r_meta_b;

    // Quadrant from the top bits after adding an eighth turn; residue in +-1/8 turn.
    always_comb begin
        w_shift = i_angle + (ANGLE_W'(1) << (ANGLE_W - 3));
        w_quad  = w_shift[ANGLE_W-1 -: 2];
        w_res   = $signed(i_angle - {w_quad, {(ANGLE_W - 2){1'b0}}});
        w_pl    = PL_W'(w_res) * $signed({1'b0, PI_LO});
        w_meta      = i_meta;
        w_meta.quad = w_quad;
    end

    // Stage A: residue times pi, as two partial products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= i_valid;
        end
        r_meta_a <= w_meta;
        r_ph     <= ACC_W'(w_res) * $signed({1'b0, PI_HI});
        r_pl     <= w_pl[PL_W-1 -: ANGLE_W + 1];
    end

    // Stage B: merge the partial products into the angle in Q60.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else begin
            r_vb <= r_va;
        end
        r_meta_b <= r_meta_a;
        r_z      <= r_ph + ACC_W'(r_pl);
    end

    assign o_valid = r_vb;
    assign o_z     = r_z;
    assign o_meta  = r_meta_b;

endmodule

// ----- rtl/afr3d_cordic_stage.sv -----
module afr3d_cordic_stage #(
    parameter int unsigned STAGE = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  afr3d_pkg::t_acc  i_x,
    input  afr3d_pkg::t_acc  i_y,
    input  afr3d_pkg::t_acc  i_z,
    input  afr3d_pkg::t_meta i_meta,
    output logic             o_valid,
    output afr3d_pkg::t_acc  o_x,
    output afr3d_pkg::t_acc  o_y,
    output afr3d_pkg::t_acc  o_z,
    output afr3d_pkg::t_meta o_meta
);
    import afr3d_pkg::*;

    localparam t_acc ATAN = t_acc'(atan_q60(STAGE));

    logic  r_valid;
    t_acc  r_x;
    t_acc  r_y;
    t_acc  r_z;
    t_meta r_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_meta <= i_meta;
        // Rotate toward zero residual angle.
        if (!i_z[ACC_W-1]) begin
            r_x <= i_x - (i_y >>> STAGE);
            r_y <= i_y + (i_x >>> STAGE);
            r_z <= i_z - ATAN;
        end else begin
            r_x <= i_x + (i_y >>> STAGE);
            r_y <= i_y - (i_x >>> STAGE);
            r_z <= i_z + ATAN;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_meta  = r_meta;

endmodule

// ----- rtl/afr3d_mix.sv -----
module afr3d_mix (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  afr3d_pkg::t_acc   i_x,
    input  afr3d_pkg::t_acc   i_y,
    input  afr3d_pkg::t_meta  i_meta,
    output logic              o_valid,
    output afr3d_pkg::t_coord o_rot_x,
    output afr3d_pkg::t_coord o_rot_y,
    output afr3d_pkg::t_coord o_rot_z,
    output logic              o_saturated
);
    import afr3d_pkg::*;

    localparam int unsigned SUM_W = ACC_W + 1;
    localparam int unsigned SH_W  = SUM_W - SC_FRAC;
    localparam t_acc        TRIG_HALF = t_acc'(64'd1 << (59 - SC_FRAC));

    typedef struct packed {
        logic   flag;
        t_coord val;
    } t_sat;

    function automatic t_sat round_sat(input logic signed [SUM_W-1:0] t);
        logic signed [SH_W-1:0] sh;
        logic [SH_W-COORD_W:0]  top;
        t_sat                   res;
        sh  = t[SUM_W-1:SC_FRAC];
        top = sh[SH_W-1:COORD_W-1];
        if ((top == '0) || (top == '1)) begin
            res.flag = 1'b0;
            res.val  = sh[COORD_W-1:0];
        end else begin
            res.flag = 1'b1;
            res.val  = sh[SH_W-1] ? {1'b1, {(COORD_W - 1){1'b0}}}
                                  : {1'b0, {(COORD_W - 1){1'b1}}};
        end
        return res;
    endfunction

    t_acc   w_cr;
    t_acc   w_sr;
    t_coord w_c;
    t_coord w_s;
    t_coord w_cq;
    t_coord w_sq;
    logic signed [SUM_W-1:0] w_t1;
    logic signed [SUM_W-1:0] w_t2;
    t_sat   w_o1;
    t_sat   w_o2;

    logic   r_v1;
    t_meta  r_m1;
    t_coord r_c;
    t_coord r_s;
    logic   r_v2;
    t_meta  r_m2;
    t_acc   r_p1a;
    t_acc   r_p1b;
    t_acc   r_p2a;
    t_acc   r_p2b;
    logic   r_v3;
    t_coord r_rx;
    t_coord r_ry;
    t_coord r_rz;
    logic   r_sat;

    // Round cos/sin to Q30 and fold the quadrant back in.
    always_comb begin
        w_cr = (i_x + TRIG_HALF) >>> (ACC_W - 4 - SC_FRAC);
        w_sr = (i_y + TRIG_HALF) >>> (ACC_W - 4 - SC_FRAC);
        w_c  = w_cr[COORD_W-1:0];
        w_s  = w_sr[COORD_W-1:0];
        unique case (i_meta.quad)
            2'd0:    begin w_cq = w_c;  w_sq = w_s;  end
            2'd1:    begin w_cq = -w_s; w_sq = w_c;  end
            2'd2:    begin w_cq = -w_c; w_sq = -w_s; end
            default: begin w_cq = w_s;  w_sq = -w_c; end
        endcase
    end

    always_comb begin
        w_t1 = SUM_W'(r_p1a) + SUM_W'(r_p1b) + SUM_W'(t_acc'(64'd1 << (SC_FRAC - 1)));
        w_t2 = SUM_W'(r_p2a) + SUM_W'(r_p2b) + SUM_W'(t_acc'(64'd1 << (SC_FRAC - 1)));
        w_o1 = round_sat(w_t1);
        w_o2 = round_sat(w_t2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_m1  <= i_meta;
        r_c   <= w_cq;
        r_s   <= w_sq;
        r_m2  <= r_m1;
        r_p1a <= r_m1.a * r_c;
        r_p1b <= r_m1.b * r_s;
        r_p2a <= r_m1.b * r_c;
        r_p2b <= r_m1.a * (-r_s);
        unique case (r_m2.axis)
            AXIS_X: begin
                r_rx  <= r_m2.pass;
                r_ry  <= w_o1.val;
                r_rz  <= w_o2.val;
                r_sat <= w_o1.flag | w_o2.flag;
            end
            AXIS_Y: begin
                r_rx  <= w_o2.val;
                r_ry  <= r_m2.pass;
                r_rz  <= w_o1.val;
                r_sat <= w_o1.flag | w_o2.flag;
            end
            AXIS_Z: begin
                r_rx  <= w_o1.val;
                r_ry  <= w_o2.val;
                r_rz  <= r_m2.pass;
                r_sat <= w_o1.flag | w_o2.flag;
            end
            default: begin
                r_rx  <= '0;
                r_ry  <= '0;
                r_rz  <= '0;
                r_sat <= 1'b0;
            end
        endcase
    end

    assign o_valid     = r_v3;
    assign o_rot_x     = r_rx;
    assign o_rot_y     = r_ry;
    assign o_rot_z     = r_rz;
    assign o_saturated = r_sat;

endmodule

// ----- rtl/axis_frame_rotation_3d.sv -----
// Elementary frame rotation of a 3D vector about the X, Y or Z axis.
//
// Request channel: drive i_vec_x/y/z (signed, 16 fraction bits), i_axis and
// i_turn_angle (2^32 per turn) with start high; the request is taken at the
// rising edge where start is high and busy is low. Busy is high only while
// reset is applied and in the first cycle after it, so a request can be
// issued on every cycle from then on.
// Result channel: o_valid pulses for one cycle with o_rot_x/y/z and
// o_saturated. There is no backpressure; the receiver must take every result.
// The default is 24 CORDIC stages. Throughput is one request per cycle:
// every stage is one register rank and none iterates.
// The depth is set by the CORDIC, one micro-rotation per stage, plus three
// ranks for angle reduction and three for the products and rounding.
// Synchronous reset clears all valid bits; requests in flight are dropped.
module axis_frame_rotation_3d #(
    parameter int unsigned TRIG_STAGES = afr3d_pkg::TRIG_STAGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  afr3d_pkg::t_coord i_vec_x,
    input  afr3d_pkg::t_coord i_vec_y,
    input  afr3d_pkg::t_coord i_vec_z,
    input  logic [1:0]        i_axis,
    input  afr3d_pkg::t_angle i_turn_angle,
    output logic              o_valid,
    output afr3d_pkg::t_coord o_rot_x,
    output afr3d_pkg::t_coord o_rot_y,
    output afr3d_pkg::t_coord o_rot_z,
    output logic              o_saturated
);
    import afr3d_pkg::*;

    localparam int unsigned LATENCY = TRIG_STAGES + 6;
    // Start value of x: the inverse CORDIC gain for this many stages.
    localparam t_acc        K_INIT  = t_acc'(cordic_k(TRIG_STAGES));

    logic   w_accept;
    t_axis  w_axis;
    t_meta  w_meta;

    logic   r_busy;
    logic   r_valid;
    t_meta  r_meta;
    t_angle r_angle;

    logic   w_v[TRIG_STAGES+1];
    t_acc   w_x[TRIG_STAGES+1];
    t_acc   w_y[TRIG_STAGES+1];
    t_acc   w_z[TRIG_STAGES+1];
    t_meta  w_m[TRIG_STAGES+1];

    assign w_accept = start && !busy;
    assign w_axis   = t_axis'(i_axis);

    // Route the two rotated components to operands a/b and keep the one on
    // the axis aside. The first output is a*c + b*s, the second b*c - a*s.
    always_comb begin
        w_meta.axis = w_axis;
        w_meta.quad = 2'd0;
        unique case (w_axis)
            AXIS_X: begin
                w_meta.a    = i_vec_y;
                w_meta.b    = i_vec_z;
                w_meta.pass = i_vec_x;
            end
            AXIS_Y: begin
                w_meta.a    = i_vec_z;
                w_meta.b    = i_vec_x;
                w_meta.pass = i_vec_y;
            end
            AXIS_Z: begin
                w_meta.a    = i_vec_x;
                w_meta.b    = i_vec_y;
                w_meta.pass = i_vec_z;
            end
            default: begin
                w_meta.a    = '0;
                w_meta.b    = '0;
                w_meta.pass = '0;
            end
        endcase
    end

    // Input rank: capture the request; hold busy through reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= 1'b0;
            r_valid <= w_accept;
        end
        r_meta  <= w_meta;
        r_angle <= i_turn_angle;
    end

    assign busy = r_busy;

    // Angle reduction: quadrant, residue and conversion to radians in Q60.
    afr3d_angle u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_valid),
        .i_angle (r_angle),
        .i_meta  (r_meta),
        .o_valid (w_v[0]),
        .o_z     (w_z[0]),
        .o_meta  (w_m[0])
    );

    assign w_x[0] = K_INIT;
    assign w_y[0] = '0;

    // CORDIC in rotation mode, one micro-rotation per register rank.
    for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cordic
        afr3d_cordic_stage #(
            .STAGE (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .i_meta  (w_m[g]),
            .o_valid (w_v[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1]),
            .o_meta  (w_m[g+1])
        );
    end

    // cos/sin rounding, products, rounding and clipping of the two components.
    afr3d_mix u_mix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_v[TRIG_STAGES]),
        .i_x         (w_x[TRIG_STAGES]),
        .i_y         (w_y[TRIG_STAGES]),
        .i_meta      (w_m[TRIG_STAGES]),
        .o_valid     (o_valid),
        .o_rot_x     (o_rot_x),
        .o_rot_y     (o_rot_y),
        .o_rot_z     (o_rot_z),
        .o_saturated (o_saturated)
    );

    // Every accepted request comes out after the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_valid)
        else $error("result missing after pipeline latency");

    // Reset leaves nothing in flight.
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && busy)
        else $error("pipeline not flushed by reset");

    // A result strobe always traces back to a request.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, LATENCY))
        else $error("result strobe without request");

endmodule

// ----- tb/rotation_checker.sv -----
module rotation_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  afr3d_pkg::t_coord i_vec_x,
    input  afr3d_pkg::t_coord i_vec_y,
    input  afr3d_pkg::t_coord i_vec_z,
    input  logic [1:0]        i_axis,
    input  afr3d_pkg::t_angle i_turn_angle,
    input  logic              o_valid,
    input  afr3d_pkg::t_coord o_rot_x,
    input  afr3d_pkg::t_coord o_rot_y,
    input  afr3d_pkg::t_coord o_rot_z,
    input  logic              o_saturated,
    output int                fail_count,
    output int                pending,
    output int                results_seen,
    output int                clipped_seen
);
    import afr3d_pkg::*;

    typedef struct packed {
        t_coord rx;
        t_coord ry;
        t_coord rz;
        logic   sat;
    } t_rotation;

    t_rotation                rotated_q[$];
    logic signed [ACC_W-1:0] arc_q60[TRIG_STAGES_DEF];
    logic signed [ACC_W-1:0] gain_q60;

    // Build the micro-rotation angles and the CORDIC gain compensation.
    initial begin
        logic [63:0] v;
        logic [63:0] root;
        logic [63:0] trial;
        logic [63:0] sum;
        logic [63:0] term;
        v = 64'd1 << 62;
        for (int unsigned i = 0; i < TRIG_STAGES_DEF && 2 * i <= 62; i++)
            v = v - v / ((64'd1 << (2 * i)) + 64'd1);
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        gain_q60 = root << 29;
        for (int unsigned i = 0; i < TRIG_STAGES_DEF; i++) begin
            if (i == 0) begin
                arc_q60[i] = PI_Q61 >> 3;
            end else begin
                sum = '0;
                for (int unsigned k = 0; i * (2 * k + 1) <= 62; k++) begin
                    term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
                    if (k[0]) sum = sum - term;
                    else      sum = sum + term;
                end
                arc_q60[i] = (sum + 64'd2) >> 2;
            end
        end
    end

    // cos and sin of a binary angle in Q30, quadrant folded back in.
    function automatic void trig_q30(input t_angle ang, output logic signed [63:0] cq,
                                     output logic signed [63:0] sq);
        logic [31:0]          shifted;
        logic [31:0]          resid;
        logic [1:0]           quad;
        logic signed [127:0]  prod;
        logic signed [63:0]   zr;
        logic signed [63:0]   xr;
        logic signed [63:0]   yr;
        logic signed [63:0]   dx;
        logic signed [63:0]   dy;
        logic signed [63:0]   cv;
        logic signed [63:0]   sv;
        shifted = ang + 32'h2000_0000;
        quad    = shifted[31:30];
        resid   = ang - {quad, 30'd0};
        prod    = $signed({resid, 32'd0}) * $signed({64'd0, PI_Q61});
        zr      = prod[127:64];
        xr      = gain_q60;
        yr      = '0;
        for (int i = 0; i < TRIG_STAGES_DEF; i++) begin
            dx = yr >>> i;
            dy = xr >>> i;
            if (zr >= 0) begin
                xr = xr - dx;
                yr = yr + dy;
                zr = zr - arc_q60[i];
            end else begin
                xr = xr + dx;
                yr = yr - dy;
                zr = zr + arc_q60[i];
            end
        end
        cv = (xr + (64'sd1 <<< 29)) >>> 30;
        sv = (yr + (64'sd1 <<< 29)) >>> 30;
        case (quad)
            2'd0:    begin cq = cv;  sq = sv;  end
            2'd1:    begin cq = -sv; sq = cv;  end
            2'd2:    begin cq = -cv; sq = -sv; end
            default: begin cq = sv;  sq = -cv; end
        endcase
    endfunction

    // p*cp + q*cq from Q30, rounded half up and clipped to the coordinate range.
    function automatic t_coord blend(input t_coord p, input logic signed [63:0] cp,
                                     input t_coord q, input logic signed [63:0] cq,
                                     inout logic clip);
        logic signed [127:0] acc;
        acc = p * cp + q * cq;
        acc = (acc + (128'sd1 <<< 29)) >>> 30;
        if (acc > 128'sd2147483647) begin
            clip = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (acc < -128'sd2147483648) begin
            clip = 1'b1;
            return 32'h8000_0000;
        end
        return acc[31:0];
    endfunction

    function automatic t_rotation rotate_vector(input t_coord vx, input t_coord vy,
                                                input t_coord vz, input t_axis ax,
                                                input t_angle ang);
        t_rotation          res;
        logic signed [63:0] cq;
        logic signed [63:0] sq;
        logic               clip;
        res  = '0;
        clip = 1'b0;
        if (ax != AXIS_NONE) begin
            trig_q30(ang, cq, sq);
            case (ax)
                AXIS_X: begin
                    res.rx = vx;
                    res.ry = blend(vy, cq, vz, sq, clip);
                    res.rz = blend(vz, cq, vy, -sq, clip);
                end
                AXIS_Y: begin
                    res.rz = blend(vz, cq, vx, sq, clip);
                    res.rx = blend(vx, cq, vz, -sq, clip);
                    res.ry = vy;
                end
                default: begin
                    res.rx = blend(vx, cq, vy, sq, clip);
                    res.ry = blend(vy, cq, vx, -sq, clip);
                    res.rz = vz;
                end
            endcase
        end
        res.sat = clip;
        return res;
    endfunction

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got, input bit wide);
        if (got !== want) begin
            fail_count++;
            if (wide)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, $signed(want), $signed(got));
            else
                $display("%0t: %s mismatch, expected %0b, actual %0b",
                         $time, name, want[0], got[0]);
        end
    endtask

    always @(posedge i_clk) begin
        t_rotation want;
        if (i_rst_n === 1'b1) begin
            if (o_valid === 1'b1) begin
                results_seen++;
                if (rotated_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with nothing outstanding, actual %0d %0d %0d %0b",
                             $time, o_rot_x, o_rot_y, o_rot_z, o_saturated);
                end else begin
                    want = rotated_q.pop_front();
                    if (want.sat) clipped_seen++;
                    report_field("rot_x", want.rx, o_rot_x, 1'b1);
                    report_field("rot_y", want.ry, o_rot_y, 1'b1);
                    report_field("rot_z", want.rz, o_rot_z, 1'b1);
                    report_field("saturated", {31'd0, want.sat}, {31'd0, o_saturated}, 1'b0);
                end
            end else if (o_valid !== 1'b0) begin
                fail_count++;
                $display("%0t: o_valid unknown, expected 0 or 1, actual %b", $time, o_valid);
            end
            if (start && !busy)
                rotated_q.push_back(rotate_vector(i_vec_x, i_vec_y, i_vec_z,
                                                  t_axis'(i_axis), i_turn_angle));
        end else begin
            // Clear the counters while reset is applied.
            fail_count   = 0;
            results_seen = 0;
            clipped_seen = 0;
        end
        pending = rotated_q.size();
    end

endmodule

// ----- tb/tb.sv -----
module tb;
    import afr3d_pkg::*;

    // Pipeline depth of the block at the default CORDIC length, plus margin.
    localparam int DRAIN_CYCLES   = TRIG_STAGES_DEF + 6 + 10;
    // Cycles with neither a request taken nor a result seen before giving up.
    localparam int STALL_LIMIT    = 1000;
    localparam int RANDOM_REQS    = 700;
    localparam t_coord COORD_MAX  = 32'sh7FFF_FFFF;
    localparam t_coord COORD_MIN  = 32'sh8000_0000;
    localparam t_coord ONE_Q16    = 32'sh0001_0000;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_coord     i_vec_x;
    t_coord     i_vec_y;
    t_coord     i_vec_z;
    logic [1:0] i_axis;
    t_angle     i_turn_angle;
    logic       o_valid;
    t_coord     o_rot_x;
    t_coord     o_rot_y;
    t_coord     o_rot_z;
    logic       o_saturated;

    int fail_count;
    int pending;
    int results_seen;
    int clipped_seen;
    int axis_sent[4];
    int sent_total;
    int quiet_cycles;

    axis_frame_rotation_3d DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_vec_x      (i_vec_x),
        .i_vec_y      (i_vec_y),
        .i_vec_z      (i_vec_z),
        .i_axis       (i_axis),
        .i_turn_angle (i_turn_angle),
        .o_valid      (o_valid),
        .o_rot_x      (o_rot_x),
        .o_rot_y      (o_rot_y),
        .o_rot_z      (o_rot_z),
        .o_saturated  (o_saturated)
    );

    rotation_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_vec_x      (i_vec_x),
        .i_vec_y      (i_vec_y),
        .i_vec_z      (i_vec_z),
        .i_axis       (i_axis),
        .i_turn_angle (i_turn_angle),
        .o_valid      (o_valid),
        .o_rot_x      (o_rot_x),
        .o_rot_y      (o_rot_y),
        .o_rot_z      (o_rot_z),
        .o_saturated  (o_saturated),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .clipped_seen (clipped_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: restart the count in reset and on every request taken or
    // result seen.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one request at the current falling edge and hold it until taken.
    // Leave start high on return so a following request keeps it asserted.
    task automatic send(input t_coord vx, input t_coord vy, input t_coord vz,
                        input t_axis ax, input t_angle ang);
        bit taken;
        start        <= 1'b1;
        i_vec_x      <= vx;
        i_vec_y      <= vy;
        i_vec_z      <= vz;
        i_axis       <= ax;
        i_turn_angle <= ang;
        do begin
            @(posedge i_clk);
            taken = !busy;
            @(negedge i_clk);
        end while (!taken);
        axis_sent[ax]++;
        sent_total++;
    endtask

    // Drop start for a number of cycles; zero means no gap at all.
    task automatic pause(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    // Mix full-range words with small values and the extremes so that both
    // ordinary rotations and clipping are exercised.
    function automatic t_coord pick_coord();
        case ($urandom_range(0, 5))
            0, 1:    return $urandom;
            2:       return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            3: begin
                case ($urandom_range(0, 4))
                    0:       return COORD_MAX;
                    1:       return COORD_MIN;
                    2:       return 32'sd0;
                    3:       return -32'sd1;
                    default: return ONE_Q16;
                endcase
            end
            default: return $signed($urandom) >>> $urandom_range(4, 12);
        endcase
    endfunction

    // Favor angles close to the octant boundaries where the quadrant fold
    // and the residue sign change.
    function automatic t_angle pick_angle();
        case ($urandom_range(0, 4))
            0:       return {3'($urandom_range(0, 7)), 29'd0}
                            + 32'($urandom_range(0, 64)) - 32'd32;
            1:       return {3'($urandom_range(0, 7)), 29'd0};
            default: return $urandom;
        endcase
    endfunction

    function automatic t_axis pick_axis();
        case ($urandom_range(0, 9))
            0:       return AXIS_NONE;
            1, 2, 3: return AXIS_X;
            4, 5, 6: return AXIS_Y;
            default: return AXIS_Z;
        endcase
    endfunction

    initial begin
        int burst;
        start        = 1'b0;
        i_rst_n      = 1'b0;
        i_vec_x      = '0;
        i_vec_y      = '0;
        i_vec_z      = '0;
        i_axis       = AXIS_X;
        i_turn_angle = '0;
        sent_total   = 0;
        foreach (axis_sent[k]) axis_sent[k] = 0;

        // Hold reset, then release it on a falling edge.
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, back to back: every axis, the quadrant and octant
        // boundaries, full-scale components that clip, and the invalid axis.
        send(ONE_Q16, 2 * ONE_Q16, 3 * ONE_Q16, AXIS_X, 32'h2000_0000);
        send(ONE_Q16, 2 * ONE_Q16, 3 * ONE_Q16, AXIS_Y, 32'h2000_0000);
        send(ONE_Q16, 2 * ONE_Q16, 3 * ONE_Q16, AXIS_Z, 32'h2000_0000);
        send(ONE_Q16, 2 * ONE_Q16, 3 * ONE_Q16, AXIS_NONE, 32'h2000_0000);
        send(COORD_MAX, COORD_MIN, COORD_MAX, AXIS_X, 32'h0000_0000);
        send(COORD_MIN, COORD_MAX, -ONE_Q16, AXIS_Y, 32'h4000_0000);
        send(COORD_MIN, COORD_MIN, 32'sd5, AXIS_Z, 32'h8000_0000);
        send(COORD_MAX, -32'sd7, COORD_MIN, AXIS_Z, 32'hC000_0000);
        send(32'sd0, COORD_MAX, COORD_MAX, AXIS_X, 32'hFFFF_FFFF);
        send(COORD_MAX, COORD_MAX, COORD_MAX, AXIS_Y, 32'hE000_0000);
        send(ONE_Q16, -ONE_Q16, COORD_MAX, AXIS_Z, 32'h1FFF_FFFF);
        send(COORD_MIN, COORD_MIN, COORD_MIN, AXIS_X, 32'h2000_0000);
        send(COORD_MAX, COORD_MIN, COORD_MAX, AXIS_NONE, 32'hFFFF_FFFF);
        send(-32'sd1, 32'sd1, -32'sd1, AXIS_Y, 32'h6000_0000);
        send(32'sd1, -32'sd1, COORD_MIN, AXIS_Z, 32'hA000_0000);
        send(32'sd0, 32'sd0, 32'sd0, AXIS_X, 32'd12345);
        send(COORD_MAX, 32'sd0, COORD_MIN, AXIS_Y, 32'h0000_0001);
        send(COORD_MAX, COORD_MAX, 32'sd0, AXIS_Z, 32'h2000_0001);
        send(32'sh1234_5678, -32'sh0765_4321, 32'sh0ABC_DEF0, AXIS_X, 32'h5555_5555);
        send(-32'sh0FED_CBA9, 32'sh0135_7924, 32'sh00FF_FF00, AXIS_Y, 32'h8000_0001);
        send(32'sh3FFF_FFFF, -32'sh4000_0000, COORD_MAX, AXIS_X, 32'h6000_0000);
        pause(3);

        // Random part: bursts of random length, gaps of random length, and
        // about a quarter of the bursts followed by no gap.
        while (sent_total < RANDOM_REQS + 21) begin
            burst = $urandom_range(1, 40);
            repeat (burst) send(pick_coord(), pick_coord(), pick_coord(),
                                pick_axis(), pick_angle());
            pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
        end
        start <= 1'b0;

        // Drain: wait for every outstanding result, then for a pipeline's worth
        // of cycles to catch any stray result.
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Requests taken: %0d (X %0d, Y %0d, Z %0d, invalid axis %0d)",
                 sent_total, axis_sent[AXIS_X], axis_sent[AXIS_Y],
                 axis_sent[AXIS_Z], axis_sent[AXIS_NONE]);
        $display("Results compared: %0d, of which %0d clipped; mismatches: %0d",
                 results_seen, clipped_seen, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
